### sv/uvpm_pkg.sv
package uvpm_pkg;

  localparam int UV_FRAC_BITS_DEF = 16;
  localparam int CORDIC_STEPS_DEF = 18;

  localparam int ROOT_STEPS = 32;
  localparam int DIFF_W     = 35;
  localparam int MAG_W      = 34;
  localparam int SQ_W       = 31;
  localparam int RAD_W      = 64;
  localparam int CV_W       = 44;
  localparam int ACC_W      = 34;
  localparam int SH_W       = 6;
  localparam int NORM_MSB   = 40;

  localparam int         MODE_SPH_BIT = 1;
  localparam logic [1:0] MODE_CYL     = 2'd1;

  localparam logic signed [ACC_W-1:0] HALF_TURN = 34'sh0_8000_0000;

  typedef enum logic [2:0] {
    REG_MODE,
    REG_MIN_X,
    REG_MIN_Y,
    REG_MIN_Z,
    REG_MAX_X,
    REG_MAX_Y,
    REG_MAX_Z
  } cfg_reg_t;

  typedef struct packed {
    logic        zero;
    logic        one;
    logic [32:0] rem;
    logic [31:0] size;
    logic [31:0] quo;
  } plane_t;

  typedef struct packed {
    logic        zero;
    logic        one;
    logic [31:0] quo;
  } plane_res_t;

  typedef struct packed {
    logic                     sph;
    logic                     cyl;
    logic [RAD_W-1:0]         rad_n;
    logic [RAD_W-1:0]         rad_res;
    logic signed [31:0]       ys;
    logic signed [DIFF_W-1:0] ux;
    logic signed [DIFF_W-1:0] uz;
    plane_t                   px;
    plane_t                   py;
  } root_t;

  typedef struct packed {
    logic                    zero;
    logic signed [CV_W-1:0]  cx;
    logic signed [CV_W-1:0]  cy;
    logic signed [ACC_W-1:0] acc;
  } lane_t;

  typedef struct packed {
    logic       sph;
    logic       cyl;
    lane_t      lu;
    lane_t      lv;
    plane_res_t px;
    plane_res_t py;
  } cord_t;

  // atan(2^-i) in 2^-32 turn units
  function automatic logic signed [ACC_W-1:0] atan_turn(input int unsigned idx);
    logic [31:0] t;
    unique case (idx[4:0])
      5'd0:  t = 32'h20000000;
      5'd1:  t = 32'h12E4051E;
      5'd2:  t = 32'h09FB385B;
      5'd3:  t = 32'h051111D4;
      5'd4:  t = 32'h028B0D43;
      5'd5:  t = 32'h0145D7E1;
      5'd6:  t = 32'h00A2F61E;
      5'd7:  t = 32'h00517C55;
      5'd8:  t = 32'h0028BE53;
      5'd9:  t = 32'h00145F2F;
      5'd10: t = 32'h000A2F98;
      5'd11: t = 32'h000517CC;
      5'd12: t = 32'h00028BE6;
      5'd13: t = 32'h000145F3;
      5'd14: t = 32'h0000A2FA;
      5'd15: t = 32'h0000517D;
      5'd16: t = 32'h000028BE;
      5'd17: t = 32'h0000145F;
      5'd18: t = 32'h00000A30;
      5'd19: t = 32'h00000518;
      5'd20: t = 32'h0000028C;
      5'd21: t = 32'h00000146;
      5'd22: t = 32'h000000A3;
      5'd23: t = 32'h00000051;
      5'd24: t = 32'h00000029;
      5'd25: t = 32'h00000014;
      5'd26: t = 32'h0000000A;
      5'd27: t = 32'h00000005;
      5'd28: t = 32'h00000003;
      5'd29: t = 32'h00000001;
      5'd30: t = 32'h00000001;
      5'd31: t = 32'h00000000;
    endcase
    return $signed(ACC_W'(t));
  endfunction

endpackage

### sv/uvpm_front.sv
module uvpm_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [1:0]              mode,
  input  logic signed [31:0]      box_min_x,
  input  logic signed [31:0]      box_min_y,
  input  logic signed [31:0]      box_min_z,
  input  logic signed [31:0]      box_max_x,
  input  logic signed [31:0]      box_max_y,
  input  logic signed [31:0]      box_max_z,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [31:0]      pos_x,
  input  logic signed [31:0]      pos_y,
  input  logic signed [31:0]      pos_z,
  output logic                    out_valid,
  input  logic                    out_ready,
  output uvpm_pkg::root_t         out_data
);

  localparam int DW = uvpm_pkg::DIFF_W;
  localparam int MW = uvpm_pkg::MAG_W;
  localparam int SW = uvpm_pkg::SQ_W;

  logic                 s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  logic                 rdy1, rdy2, rdy3, rdy4;
  logic                 s1_sph_r, s1_cyl_r;
  logic signed [DW-1:0] s1_dx_r, s1_dy_r, s1_dz_r, s1_ux_r, s1_uz_r;
  logic signed [32:0]   s1_dfx_r, s1_szx_r, s1_dfy_r, s1_szy_r;
  uvpm_pkg::root_t      s2_data_r, s3_data_r, s4_data_r;
  logic [SW-1:0]        s2_mx_r, s2_mz_r;
  logic [2*SW-1:0]      s3_sqx_r, s3_sqz_r;

  logic signed [DW-1:0] px_e, py_e, pz_e;
  logic signed [DW-1:0] dx_nxt, dy_nxt, dz_nxt;
  logic [MW-1:0]        mx, my, mz, mor, mx_sh, my_sh, mz_sh;
  logic [1:0]           sh;
  uvpm_pkg::root_t      s2_nxt, s4_nxt;

  function automatic logic [MW-1:0] mag(input logic signed [DW-1:0] d);
    logic signed [DW-1:0] a;
    a = (d < 0) ? -d : d;
    return a[MW-1:0];
  endfunction

  function automatic uvpm_pkg::plane_t plane_init(input logic signed [32:0] df,
                                                  input logic signed [32:0] sz);
    uvpm_pkg::plane_t p;
    p.zero = (sz <= 0) || (df <= 0);
    p.one  = (df >= sz);
    p.rem  = df;
    p.size = sz[31:0];
    p.quo  = '0;
    return p;
  endfunction

  assign rdy4     = !s4_v_r || out_ready;
  assign rdy3     = !s3_v_r || rdy4;
  assign rdy2     = !s2_v_r || rdy3;
  assign rdy1     = !s1_v_r || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    px_e   = $signed({{3{pos_x[31]}}, pos_x});
    py_e   = $signed({{3{pos_y[31]}}, pos_y});
    pz_e   = $signed({{3{pos_z[31]}}, pos_z});
    dx_nxt = (px_e <<< 1) - (DW'(box_min_x) + DW'(box_max_x));
    dy_nxt = (py_e <<< 1) - (DW'(box_min_y) + DW'(box_max_y));
    dz_nxt = (pz_e <<< 1) - (DW'(box_min_z) + DW'(box_max_z));
  end

  always_comb begin
    mx  = mag(s1_dx_r);
    my  = mag(s1_dy_r);
    mz  = mag(s1_dz_r);
    mor = mx | my | mz;
    priority if (mor[33]) begin
      sh = 2'd3;
    end else if (mor[32]) begin
      sh = 2'd2;
    end else if (mor[31]) begin
      sh = 2'd1;
    end else begin
      sh = 2'd0;
    end
    mx_sh = mx >> sh;
    my_sh = my >> sh;
    mz_sh = mz >> sh;
    s2_nxt.sph     = s1_sph_r;
    s2_nxt.cyl     = s1_cyl_r;
    s2_nxt.rad_n   = '0;
    s2_nxt.rad_res = '0;
    s2_nxt.ys      = (s1_dy_r < 0) ? -$signed({1'b0, my_sh[SW-1:0]})
                                   : $signed({1'b0, my_sh[SW-1:0]});
    s2_nxt.ux      = s1_ux_r;
    s2_nxt.uz      = s1_uz_r;
    s2_nxt.px      = plane_init(s1_dfx_r, s1_szx_r);
    s2_nxt.py      = plane_init(s1_dfy_r, s1_szy_r);
  end

  always_comb begin
    s4_nxt       = s3_data_r;
    s4_nxt.rad_n = uvpm_pkg::RAD_W'(s3_sqx_r) + uvpm_pkg::RAD_W'(s3_sqz_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      if (rdy1) s1_v_r <= in_valid;
      if (rdy2) s2_v_r <= s1_v_r;
      if (rdy3) s3_v_r <= s2_v_r;
      if (rdy4) s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      s1_sph_r <= mode[uvpm_pkg::MODE_SPH_BIT];
      s1_cyl_r <= (mode == uvpm_pkg::MODE_CYL);
      s1_dx_r  <= dx_nxt;
      s1_dy_r  <= dy_nxt;
      s1_dz_r  <= dz_nxt;
      s1_ux_r  <= mode[uvpm_pkg::MODE_SPH_BIT] ? dx_nxt : px_e;
      s1_uz_r  <= mode[uvpm_pkg::MODE_SPH_BIT] ? dz_nxt : pz_e;
      s1_dfx_r <= $signed({pos_x[31], pos_x}) - $signed({box_min_x[31], box_min_x});
      s1_szx_r <= $signed({box_max_x[31], box_max_x}) - $signed({box_min_x[31], box_min_x});
      s1_dfy_r <= $signed({pos_y[31], pos_y}) - $signed({box_min_y[31], box_min_y});
      s1_szy_r <= $signed({box_max_y[31], box_max_y}) - $signed({box_min_y[31], box_min_y});
    end
    if (rdy2 && s1_v_r) begin
      s2_data_r <= s2_nxt;
      s2_mx_r   <= mx_sh[SW-1:0];
      s2_mz_r   <= mz_sh[SW-1:0];
    end
    if (rdy3 && s2_v_r) begin
      s3_data_r <= s2_data_r;
      s3_sqx_r  <= (2*SW)'(s2_mx_r) * (2*SW)'(s2_mx_r);
      s3_sqz_r  <= (2*SW)'(s2_mz_r) * (2*SW)'(s2_mz_r);
    end
    if (rdy4 && s3_v_r) begin
      s4_data_r <= s4_nxt;
    end
  end

  assign out_valid = s4_v_r;
  assign out_data  = s4_data_r;

endmodule

### sv/uvpm_root_cell.sv
module uvpm_root_cell #(
  parameter int STEP = 0,
  parameter int UVF  = uvpm_pkg::UV_FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  uvpm_pkg::root_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output uvpm_pkg::root_t out_data
);

  localparam int RW = uvpm_pkg::RAD_W;
  localparam logic [RW-1:0] BIT_C = RW'(1) << (2 * (uvpm_pkg::ROOT_STEPS - 1 - STEP));

  logic            vld_r;
  uvpm_pkg::root_t data_r, data_nxt;
  logic [RW-1:0]   trial;

  function automatic uvpm_pkg::plane_t div_step(input uvpm_pkg::plane_t p);
    logic [32:0]      r2;
    uvpm_pkg::plane_t q;
    r2 = {p.rem[31:0], 1'b0};
    q  = p;
    if (r2 >= {1'b0, p.size}) begin
      q.rem = r2 - {1'b0, p.size};
      q.quo = {p.quo[30:0], 1'b1};
    end else begin
      q.rem = r2;
      q.quo = {p.quo[30:0], 1'b0};
    end
    return q;
  endfunction

  assign in_ready = !vld_r || out_ready;

  always_comb begin
    data_nxt = in_data;
    trial    = in_data.rad_res + BIT_C;
    if (in_data.rad_n >= trial) begin
      data_nxt.rad_n   = in_data.rad_n - trial;
      data_nxt.rad_res = (in_data.rad_res >> 1) + BIT_C;
    end else begin
      data_nxt.rad_res = in_data.rad_res >> 1;
    end
    if (STEP < UVF) begin
      data_nxt.px = div_step(in_data.px);
      data_nxt.py = div_step(in_data.py);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = vld_r;
  assign out_data  = data_r;

endmodule

### sv/uvpm_norm.sv
module uvpm_norm (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  uvpm_pkg::root_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output uvpm_pkg::cord_t out_data
);

  localparam int DW = uvpm_pkg::DIFF_W;
  localparam int CW = uvpm_pkg::CV_W;
  localparam int SHW = uvpm_pkg::SH_W;

  typedef struct packed {
    logic                              zero;
    logic                              yneg;
    logic [DW-1:0]                     ax;
    logic [DW-1:0]                     ay;
    logic signed [uvpm_pkg::ACC_W-1:0] acc;
    logic [SHW-1:0]                    sh;
  } pre_t;

  logic                 n1_v_r, n2_v_r, rdy1, rdy2;
  logic                 n1_sph_r, n1_cyl_r;
  pre_t                 n1_pu_r, n1_pv_r;
  uvpm_pkg::plane_res_t n1_px_r, n1_py_r;
  uvpm_pkg::cord_t      n2_data_r, n2_nxt;
  logic signed [DW-1:0] vx, vy;

  function automatic pre_t prep(input logic signed [DW-1:0] x,
                                input logic signed [DW-1:0] y);
    logic [DW-1:0] ax, ay, m;
    pre_t          p;
    ax     = (x < 0) ? $unsigned(-x) : $unsigned(x);
    ay     = (y < 0) ? $unsigned(-y) : $unsigned(y);
    m      = (ax > ay) ? ax : ay;
    p.sh   = '0;
    for (int i = 0; i < DW; i++) begin
      if (m[i]) p.sh = SHW'(uvpm_pkg::NORM_MSB - i);
    end
    p.zero = (m == '0);
    p.yneg = (y < 0) ^ (x < 0);
    p.ax   = ax;
    p.ay   = ay;
    if (x < 0) begin
      p.acc = (y < 0) ? -uvpm_pkg::HALF_TURN : uvpm_pkg::HALF_TURN;
    end else begin
      p.acc = '0;
    end
    return p;
  endfunction

  function automatic uvpm_pkg::lane_t expand(input pre_t p);
    logic signed [CW-1:0] c;
    uvpm_pkg::lane_t      l;
    l.zero = p.zero;
    l.cx   = $signed(CW'(p.ax) << p.sh);
    c      = $signed(CW'(p.ay) << p.sh);
    l.cy   = p.yneg ? -c : c;
    l.acc  = p.acc;
    return l;
  endfunction

  function automatic uvpm_pkg::plane_res_t plane_out(input uvpm_pkg::plane_t p);
    uvpm_pkg::plane_res_t r;
    r.zero = p.zero;
    r.one  = p.one;
    r.quo  = p.quo;
    return r;
  endfunction

  assign rdy2     = !n2_v_r || out_ready;
  assign rdy1     = !n1_v_r || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    vx = $signed(DW'(in_data.rad_res[31:0]));
    vy = DW'(in_data.ys);
  end

  always_comb begin
    n2_nxt.sph = n1_sph_r;
    n2_nxt.cyl = n1_cyl_r;
    n2_nxt.lu  = expand(n1_pu_r);
    n2_nxt.lv  = expand(n1_pv_r);
    n2_nxt.px  = n1_px_r;
    n2_nxt.py  = n1_py_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n1_v_r <= 1'b0;
      n2_v_r <= 1'b0;
    end else begin
      if (rdy1) n1_v_r <= in_valid;
      if (rdy2) n2_v_r <= n1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      n1_sph_r <= in_data.sph;
      n1_cyl_r <= in_data.cyl;
      n1_pu_r  <= prep(in_data.ux, in_data.uz);
      n1_pv_r  <= prep(vx, vy);
      n1_px_r  <= plane_out(in_data.px);
      n1_py_r  <= plane_out(in_data.py);
    end
    if (rdy2 && n1_v_r) begin
      n2_data_r <= n2_nxt;
    end
  end

  assign out_valid = n2_v_r;
  assign out_data  = n2_data_r;

endmodule

### sv/uvpm_cordic_cell.sv
module uvpm_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  uvpm_pkg::cord_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output uvpm_pkg::cord_t out_data
);

  localparam logic signed [uvpm_pkg::ACC_W-1:0] ANG = uvpm_pkg::atan_turn(STEP);

  logic            vld_r;
  uvpm_pkg::cord_t data_r, data_nxt;

  function automatic uvpm_pkg::lane_t rot(input uvpm_pkg::lane_t l);
    logic signed [uvpm_pkg::CV_W-1:0] tx, ty;
    uvpm_pkg::lane_t                  r;
    tx = l.cx >>> STEP;
    ty = l.cy >>> STEP;
    r  = l;
    if (l.cy >= 0) begin
      r.cx  = l.cx + ty;
      r.cy  = l.cy - tx;
      r.acc = l.acc + ANG;
    end else begin
      r.cx  = l.cx - ty;
      r.cy  = l.cy + tx;
      r.acc = l.acc - ANG;
    end
    return r;
  endfunction

  assign in_ready = !vld_r || out_ready;

  always_comb begin
    data_nxt    = in_data;
    data_nxt.lu = rot(in_data.lu);
    data_nxt.lv = rot(in_data.lv);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = vld_r;
  assign out_data  = data_r;

endmodule

### sv/uv_projection_mapping_unit.sv
// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid / in_ready    | in_pos_x, in_pos_y, in_pos_z (signed Q16.16)
// out     | output    | out_valid / out_ready  | out_tex_u, out_tex_v (Q1.UV_FRAC_BITS)
// cfg     | input     | cfg_wr_en              | cfg_index, cfg_wdata
//
// One item per cycle sustained while out_ready stays high; the path runs through 4 front stages,
// 32 square-root cells (which also run the planar divide), 2 normalise stages,
// one CORDIC cell per step and the output register.
// Synchronous active-low reset clears every valid bit and the config registers.
// Each stage holds its item until the next one frees, so bubbles collapse under stall.
module uv_projection_mapping_unit #(
  parameter int UV_FRAC_BITS = uvpm_pkg::UV_FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = uvpm_pkg::CORDIC_STEPS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic [2:0]              cfg_index,
  input  logic [31:0]             cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [31:0]      in_pos_x,
  input  logic signed [31:0]      in_pos_y,
  input  logic signed [31:0]      in_pos_z,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [UV_FRAC_BITS:0]   out_tex_u,
  output logic [UV_FRAC_BITS:0]   out_tex_v
);

  localparam int NR = uvpm_pkg::ROOT_STEPS;
  localparam logic signed [35:0] HALF_W = 36'(uvpm_pkg::HALF_TURN);

  logic [1:0]         mode_r;
  logic signed [31:0] min_x_r, min_y_r, min_z_r, max_x_r, max_y_r, max_z_r;

  uvpm_pkg::root_t root_d   [0:NR];
  logic            root_v   [0:NR];
  logic            root_rdy [0:NR];
  uvpm_pkg::cord_t cord_d   [0:CORDIC_STEPS];
  logic            cord_v   [0:CORDIC_STEPS];
  logic            cord_rdy [0:CORDIC_STEPS];

  logic                  out_valid_r, out_rdy;
  logic [UV_FRAC_BITS:0] tex_u_r, tex_v_r, tex_u_nxt, tex_v_nxt;
  logic signed [35:0]    au, av, wu, wv;
  uvpm_pkg::cord_t       fin;

  function automatic logic [UV_FRAC_BITS:0] to_uv(input logic signed [35:0] w);
    logic [35:0]           r;
    logic [UV_FRAC_BITS:0] res;
    r = ($unsigned(w) + (36'd1 << (31 - UV_FRAC_BITS))) >> (32 - UV_FRAC_BITS);
    priority if (w <= 0) begin
      res = '0;
    end else if (r > (36'd1 << UV_FRAC_BITS)) begin
      res = (UV_FRAC_BITS+1)'(1) << UV_FRAC_BITS;
    end else begin
      res = r[UV_FRAC_BITS:0];
    end
    return res;
  endfunction

  function automatic logic [UV_FRAC_BITS:0] plane_uv(input uvpm_pkg::plane_res_t p);
    logic [UV_FRAC_BITS:0] res;
    priority if (p.zero) begin
      res = '0;
    end else if (p.one) begin
      res = (UV_FRAC_BITS+1)'(1) << UV_FRAC_BITS;
    end else begin
      res = {1'b0, p.quo[UV_FRAC_BITS-1:0]};
    end
    return res;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= '0;
      min_x_r <= '0;
      min_y_r <= '0;
      min_z_r <= '0;
      max_x_r <= '0;
      max_y_r <= '0;
      max_z_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (uvpm_pkg::cfg_reg_t'(cfg_index))
        uvpm_pkg::REG_MODE:  mode_r  <= cfg_wdata[1:0];
        uvpm_pkg::REG_MIN_X: min_x_r <= $signed(cfg_wdata);
        uvpm_pkg::REG_MIN_Y: min_y_r <= $signed(cfg_wdata);
        uvpm_pkg::REG_MIN_Z: min_z_r <= $signed(cfg_wdata);
        uvpm_pkg::REG_MAX_X: max_x_r <= $signed(cfg_wdata);
        uvpm_pkg::REG_MAX_Y: max_y_r <= $signed(cfg_wdata);
        uvpm_pkg::REG_MAX_Z: max_z_r <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  uvpm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .mode      (mode_r),
    .box_min_x (min_x_r),
    .box_min_y (min_y_r),
    .box_min_z (min_z_r),
    .box_max_x (max_x_r),
    .box_max_y (max_y_r),
    .box_max_z (max_z_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .pos_x     (in_pos_x),
    .pos_y     (in_pos_y),
    .pos_z     (in_pos_z),
    .out_valid (root_v[0]),
    .out_ready (root_rdy[0]),
    .out_data  (root_d[0])
  );

  for (genvar k = 0; k < NR; k++) begin : g_root
    uvpm_root_cell #(
      .STEP (k),
      .UVF  (UV_FRAC_BITS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (root_v[k]),
      .in_ready  (root_rdy[k]),
      .in_data   (root_d[k]),
      .out_valid (root_v[k+1]),
      .out_ready (root_rdy[k+1]),
      .out_data  (root_d[k+1])
    );
  end

  uvpm_norm u_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (root_v[NR]),
    .in_ready  (root_rdy[NR]),
    .in_data   (root_d[NR]),
    .out_valid (cord_v[0]),
    .out_ready (cord_rdy[0]),
    .out_data  (cord_d[0])
  );

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    uvpm_cordic_cell #(
      .STEP (i)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (cord_v[i]),
      .in_ready  (cord_rdy[i]),
      .in_data   (cord_d[i]),
      .out_valid (cord_v[i+1]),
      .out_ready (cord_rdy[i+1]),
      .out_data  (cord_d[i+1])
    );
  end

  assign fin                    = cord_d[CORDIC_STEPS];
  assign out_rdy                = !out_valid_r || out_ready;
  assign cord_rdy[CORDIC_STEPS] = out_rdy;

  always_comb begin
    au = fin.lu.zero ? '0 : 36'(fin.lu.acc);
    av = fin.lv.zero ? '0 : 36'(fin.lv.acc);
    wu = HALF_W + au;
    wv = HALF_W - (av <<< 1);
    tex_u_nxt = (fin.sph || fin.cyl) ? to_uv(wu) : plane_uv(fin.px);
    tex_v_nxt = fin.sph ? to_uv(wv) : plane_uv(fin.py);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_rdy) begin
      out_valid_r <= cord_v[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy && cord_v[CORDIC_STEPS]) begin
      tex_u_r <= tex_u_nxt;
      tex_v_r <= tex_v_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_tex_u = tex_u_r;
  assign out_tex_v = tex_v_r;

endmodule
